// ===== hdl/glu_pkg.sv =====
// ============================================================================
// glu_pkg
// Shared command and status types for the GCD/LCM unit.
// ============================================================================
`default_nettype none

package glu_pkg;

    typedef struct packed {
        logic load;         // capture operands into x/y and a/b
        logic eu_start;     // start x mod y on the shared divider
        logic div_step;     // advance the divider one quotient bit
        logic eu_swap;      // x <= y, y <= remainder
        logic q_start;      // capture divisor, start a / divisor
        logic result_load;  // write the result registers
    } cmd_t;

    typedef struct packed {
        logic xy_zero;      // x or y is zero: Euclid loop is done
        logic ab_zero;      // an operand is zero: multiple is zero
        logic div_last;     // divider is on its last bit
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/glu_if.sv =====
// ============================================================================
// glu_req_if / glu_rsp_if
// Valid/ready channels for operand requests and results.
// ============================================================================
`default_nettype none

interface glu_req_if #(
    parameter int OPERAND_BITS = 31
);
    logic                    valid;
    logic                    ready;
    logic [OPERAND_BITS-1:0] first_value;
    logic [OPERAND_BITS-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface glu_rsp_if #(
    parameter int OPERAND_BITS = 31
);
    logic                      valid;
    logic                      ready;
    logic [OPERAND_BITS-1:0]   divisor;
    logic [2*OPERAND_BITS-1:0] multiple;

    modport source (output valid, output divisor, output multiple, input ready);
    modport sink   (input valid, input divisor, input multiple, output ready);
endinterface

`default_nettype wire

// ===== hdl/glu_ctrl.sv =====
// ============================================================================
// glu_ctrl
// Sequencer for the Euclid loop, the quotient pass and result hand-off.
// ============================================================================
`default_nettype none

module glu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output glu_pkg::cmd_t         cmd,
    input  wire glu_pkg::status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_EUDIV  = 3'd2;
    localparam logic [2:0] ST_SWAP   = 3'd3;
    localparam logic [2:0] ST_QDIV   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.xy_zero)
                begin
                    cmd.q_start = 1'b1;
                    state_next  = status.ab_zero ? ST_FINISH : ST_QDIV;
                end
                else
                begin
                    cmd.eu_start = 1'b1;
                    state_next   = ST_EUDIV;
                end
            end
            ST_EUDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                cmd.eu_swap = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_QDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/glu_datapath.sv =====
// ============================================================================
// glu_datapath
// Operand registers, shared restoring divider, multiplier, result registers.
// ============================================================================
`default_nettype none

module glu_datapath #(
    parameter int OPERAND_BITS = 31
) (
    input  wire logic                      clk,
    input  wire logic [OPERAND_BITS-1:0]   first_value,
    input  wire logic [OPERAND_BITS-1:0]   second_value,
    input  wire glu_pkg::cmd_t             cmd,
    output glu_pkg::status_t               status,
    output logic [OPERAND_BITS-1:0]        divisor,
    output logic [2*OPERAND_BITS-1:0]      multiple
);

    localparam int N  = OPERAND_BITS;
    localparam int CW = $clog2(N);
    localparam logic [CW-1:0] LAST_BIT = CW'(N - 1);

    logic [N-1:0]   a_reg;
    logic [N-1:0]   b_reg;
    logic [N-1:0]   x_reg;
    logic [N-1:0]   y_reg;
    logic [N-1:0]   den_reg;
    logic [N-1:0]   rem_reg;
    logic [N-1:0]   quo_reg;
    logic [N-1:0]   g_reg;
    logic [CW-1:0]  cnt_reg;
    logic [N-1:0]   divisor_reg;
    logic [2*N-1:0] multiple_reg;

    logic [N:0]     shifted;
    logic [N+1:0]   trial;
    logic           fits;
    logic [N-1:0]   rem_next;
    logic [N-1:0]   quo_next;
    logic [2*N-1:0] product;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[N-1]};
        trial    = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !trial[N+1];
        rem_next = fits ? trial[N-1:0] : shifted[N-1:0];
        quo_next = {quo_reg[N-2:0], fits};
        product  = quo_reg * b_reg;
    end

    assign status.xy_zero  = (x_reg == '0) || (y_reg == '0);
    assign status.ab_zero  = (a_reg == '0) || (b_reg == '0);
    assign status.div_last = (cnt_reg == LAST_BIT);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= first_value;
            b_reg <= second_value;
            x_reg <= first_value;
            y_reg <= second_value;
        end
        if (cmd.eu_start)
        begin
            den_reg <= y_reg;
            quo_reg <= x_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.q_start)
        begin
            den_reg <= x_reg | y_reg;
            g_reg   <= x_reg | y_reg;
            quo_reg <= a_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.eu_swap)
        begin
            x_reg <= den_reg;
            y_reg <= rem_reg;
        end
        if (cmd.result_load)
        begin
            divisor_reg  <= g_reg;
            multiple_reg <= status.ab_zero ? '0 : product;
        end
    end

    assign divisor  = divisor_reg;
    assign multiple = multiple_reg;

endmodule

`default_nettype wire

// ===== hdl/gcd_lcm_unit.sv =====
// ============================================================================
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two unsigned operands.
// ============================================================================
// One request is worked at a time. The shared restoring divider retires one
// quotient bit per cycle; each Euclid step is a test, a divide and a swap.
// The multiple then takes one more divide of the first operand by the divisor
// and a multiply, registered into the result register. The Euclid loop runs
// at most about 45 steps at 31 bits; with a zero operand the divide of the
// quotient pass is skipped. A finished result waits in its output register
// while the next request is accepted.
// ============================================================================
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_BITS = 31
) (
    input  wire logic clk,
    input  wire logic rst_n,
    glu_req_if.sink   request,
    glu_rsp_if.source result
);

    glu_pkg::cmd_t    cmd;
    glu_pkg::status_t status;

    glu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    glu_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .clk          (clk),
        .first_value  (request.first_value),
        .second_value (request.second_value),
        .cmd          (cmd),
        .status       (status),
        .divisor      (result.divisor),
        .multiple     (result.multiple)
    );

    a_busy_after_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready
    ) else $error("request accepted while a computation is in flight");

    a_zero_divisor_zero_multiple: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && (result.divisor == '0) |-> (result.multiple == '0)
    ) else $error("zero divisor with nonzero multiple");

    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !result.valid || result.ready
    ) else $error("pending result overwritten");

endmodule

`default_nettype wire
